>>> rtl/core/cluster_medoid_update_defines.svh
// Assertion macros shared by the cluster medoid update checkers.
`ifndef CLUSTER_MEDOID_UPDATE_DEFINES_SVH
`define CLUSTER_MEDOID_UPDATE_DEFINES_SVH

// Clocked assertion, off while reset is held.
`define CMU_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked assertion that also covers the reset cycles.
`define CMU_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

>>> rtl/core/cmu_pkg.sv
// Shared constants, types and helpers for the cluster medoid update block.
`timescale 1ns / 1ps
package cmu_pkg;
    localparam int MAX_POINTS   = 256;
    localparam int MAX_CLUSTERS = 32;
    localparam int DIST_W       = 32;

    localparam int PT_W        = $clog2(MAX_POINTS);
    localparam int PCNT_W      = PT_W + 1;
    localparam int DIST_DEPTH  = 1 << (2 * PT_W);
    localparam int CID_W       = 5;
    localparam int MEMB_W      = CID_W + 1;
    localparam int CCNT_W      = 6;
    localparam int CL_LIMIT    = (MAX_CLUSTERS < 32) ? MAX_CLUSTERS : 32;
    localparam int SUM_W       = DIST_W + PT_W;
    localparam int COST_W      = 40;
    localparam int MEDIAN_W    = 8;
    localparam int FIELD_PT_W  = 8;
    localparam int FIELD_DST_W = 32;

    localparam int IN_DATA_W   = 56;
    localparam int IN_USER_W   = 2;
    localparam int OUT_DATA_W  = 56;
    localparam int OUT_USER_W  = 1;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 9;
    localparam int PCFG_W      = 9;

    localparam int QDEPTH      = 2;
    localparam int QPTR_W      = $clog2(QDEPTH);

    localparam logic [IN_USER_W-1:0] CMD_LOAD_MEMB = 2'd0;
    localparam logic [IN_USER_W-1:0] CMD_LOAD_DIST = 2'd1;
    localparam logic [IN_USER_W-1:0] CMD_RUN       = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_POINT_COUNT  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MEDIAN_COUNT = 1'd1;

    typedef enum logic [1:0] {
        K_MEMB = 2'd0,
        K_DIST = 2'd1,
        K_RUN  = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind             kind;
        logic [PT_W-1:0]   row;
        logic [PT_W-1:0]   col;
        logic [CID_W-1:0]  cid;
        logic              asg;
        logic [DIST_W-1:0] distance;
    } t_item;

    typedef struct packed {
        logic [PCNT_W-1:0] np;
        logic [CCNT_W-1:0] nc;
    } t_run_cfg;

    function automatic logic [COST_W-1:0] sat_cost(input logic [SUM_W-1:0] s);
        logic [SUM_W+COST_W-1:0] w;
        w = (SUM_W + COST_W)'(s);
        if (w > (SUM_W + COST_W)'({COST_W{1'b1}}))
            return {COST_W{1'b1}};
        return COST_W'(w);
    endfunction
endpackage

>>> rtl/core/cmu_front.sv
// Front end: accepts input transactions, classifies them and queues them.
`timescale 1ns / 1ps
module cmu_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // row_point[7:0], col_point[15:8], cluster_id[20:16], is_assigned[21],
    // distance[53:22], zero pad[55:54]
    input  logic [cmu_pkg::IN_DATA_W-1:0] s_axis_tdata,
    // cmd[1:0]
    input  logic [cmu_pkg::IN_USER_W-1:0] s_axis_tuser,
    output cmu_pkg::t_item                o_item,
    output logic                          o_item_valid,
    input  logic                          i_item_pop
);
    logic [cmu_pkg::FIELD_PT_W-1:0]  f_row;
    logic [cmu_pkg::FIELD_PT_W-1:0]  f_col;
    logic [cmu_pkg::CID_W-1:0]       f_cid;
    logic                            f_asg;
    logic [cmu_pkg::FIELD_DST_W-1:0] f_dist;
    logic                            w_row_ok;
    logic                            w_col_ok;
    logic                            w_keep;
    logic                            w_push;
    cmu_pkg::t_item                  w_item;

    cmu_pkg::t_item          r_q [cmu_pkg::QDEPTH];
    logic [cmu_pkg::QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [cmu_pkg::QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [cmu_pkg::QPTR_W:0]   r_count, n_count;

    assign f_row  = s_axis_tdata[7:0];
    assign f_col  = s_axis_tdata[15:8];
    assign f_cid  = s_axis_tdata[20:16];
    assign f_asg  = s_axis_tdata[21];
    assign f_dist = s_axis_tdata[53:22];

    assign w_row_ok = 32'(f_row) < cmu_pkg::MAX_POINTS;
    assign w_col_ok = 32'(f_col) < cmu_pkg::MAX_POINTS;

    always_comb begin
        w_item.row      = cmu_pkg::PT_W'(f_row);
        w_item.col      = cmu_pkg::PT_W'(f_col);
        w_item.cid      = f_cid;
        w_item.asg      = f_asg;
        w_item.distance = cmu_pkg::DIST_W'(f_dist);
        w_item.kind     = cmu_pkg::K_RUN;
        w_keep          = 1'b0;
        unique case (s_axis_tuser)
            cmu_pkg::CMD_LOAD_MEMB: begin
                w_item.kind = cmu_pkg::K_MEMB;
                w_keep      = w_row_ok;
            end
            cmu_pkg::CMD_LOAD_DIST: begin
                w_item.kind = cmu_pkg::K_DIST;
                w_keep      = w_row_ok && w_col_ok;
            end
            cmu_pkg::CMD_RUN: begin
                w_item.kind = cmu_pkg::K_RUN;
                w_keep      = 1'b1;
            end
            default: w_keep = 1'b0;
        endcase
    end

    assign s_axis_tready = r_count < (cmu_pkg::QPTR_W + 1)'(cmu_pkg::QDEPTH);
    assign w_push        = s_axis_tvalid && s_axis_tready && w_keep;
    assign o_item_valid  = r_count != '0;
    assign o_item        = r_q[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = r_wr_ptr + 1'b1;
        end
        if (i_item_pop && o_item_valid) begin
            n_rd_ptr = r_rd_ptr + 1'b1;
        end
        if (w_push && !(i_item_pop && o_item_valid)) begin
            n_count = r_count + 1'b1;
        end else if (!w_push && i_item_pop && o_item_valid) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr_ptr] <= w_item;
        end
    end
endmodule

>>> rtl/core/cmu_back.sv
// Back end: stores, medoid search sequencer and result output register.
`timescale 1ns / 1ps
module cmu_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  cmu_pkg::t_item                 i_item,
    input  logic                           i_item_valid,
    output logic                           o_item_pop,
    input  cmu_pkg::t_run_cfg              i_cfg,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // cluster_index[4:0], new_median[12:5], best_cost[52:13], zero pad[55:53]
    output logic [cmu_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // cluster_empty[0]
    output logic [cmu_pkg::OUT_USER_W-1:0] m_axis_tuser,
    output logic                           m_axis_tlast
);
    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_JRD  = 6'b000010,
        S_JCHK = 6'b000100,
        S_K    = 6'b001000,
        S_KEND = 6'b010000,
        S_OUT  = 6'b100000
    } t_state;

    logic [cmu_pkg::DIST_W-1:0] m_dist [cmu_pkg::DIST_DEPTH];
    logic [cmu_pkg::MEMB_W-1:0] m_memb [cmu_pkg::MAX_POINTS];

    t_state                       r_state, n_state;
    logic [cmu_pkg::CCNT_W-1:0]   r_c, n_c;
    logic [cmu_pkg::PCNT_W-1:0]   r_j, n_j;
    logic [cmu_pkg::PCNT_W-1:0]   r_k, n_k;
    logic                         r_acc_vld, n_acc_vld;
    logic [cmu_pkg::SUM_W-1:0]    r_sum, n_sum;
    logic [cmu_pkg::SUM_W-1:0]    r_best_sum, n_best_sum;
    logic [cmu_pkg::PT_W-1:0]     r_best, n_best;
    logic                         r_found, n_found;
    logic [cmu_pkg::MEMB_W-1:0]   r_memb_q;
    logic [cmu_pkg::DIST_W-1:0]   r_dist_q;

    logic                         r_o_valid, n_o_valid;
    logic [cmu_pkg::CID_W-1:0]    r_o_idx, n_o_idx;
    logic [cmu_pkg::MEDIAN_W-1:0] r_o_med, n_o_med;
    logic                         r_o_empty, n_o_empty;
    logic [cmu_pkg::COST_W-1:0]   r_o_cost, n_o_cost;
    logic                         r_o_last, n_o_last;

    logic                         w_memb_we;
    logic                         w_dist_we;
    logic [cmu_pkg::PT_W-1:0]     w_memb_raddr;
    logic [2*cmu_pkg::PT_W-1:0]   w_dist_raddr;
    logic [cmu_pkg::MEMB_W-1:0]   w_tag;
    logic                         w_is_last;

    assign w_tag        = {1'b1, r_c[cmu_pkg::CID_W-1:0]};
    assign w_memb_raddr = (r_state == S_K) ? r_k[cmu_pkg::PT_W-1:0] : r_j[cmu_pkg::PT_W-1:0];
    assign w_dist_raddr = {r_j[cmu_pkg::PT_W-1:0], r_k[cmu_pkg::PT_W-1:0]};
    assign w_memb_we    = (r_state == S_IDLE) && i_item_valid && (i_item.kind == cmu_pkg::K_MEMB);
    assign w_dist_we    = (r_state == S_IDLE) && i_item_valid && (i_item.kind == cmu_pkg::K_DIST);
    assign o_item_pop   = (r_state == S_IDLE) && i_item_valid;
    assign w_is_last    = cmu_pkg::CCNT_W'(r_c + 1'b1) == i_cfg.nc;

    always_ff @(posedge i_clk) begin
        if (w_memb_we) begin
            m_memb[i_item.row] <= {i_item.asg, i_item.cid};
        end
        r_memb_q <= m_memb[w_memb_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (w_dist_we) begin
            m_dist[{i_item.row, i_item.col}] <= i_item.distance;
        end
        r_dist_q <= m_dist[w_dist_raddr];
    end

    always_comb begin
        n_state    = r_state;
        n_c        = r_c;
        n_j        = r_j;
        n_k        = r_k;
        n_acc_vld  = 1'b0;
        n_sum      = r_sum;
        n_best_sum = r_best_sum;
        n_best     = r_best;
        n_found    = r_found;
        n_o_valid  = r_o_valid && !m_axis_tready;
        n_o_idx    = r_o_idx;
        n_o_med    = r_o_med;
        n_o_empty  = r_o_empty;
        n_o_cost   = r_o_cost;
        n_o_last   = r_o_last;

        if (r_acc_vld && (r_memb_q == w_tag)) begin
            n_sum = r_sum + cmu_pkg::SUM_W'(r_dist_q);
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_item_valid && (i_item.kind == cmu_pkg::K_RUN) && (i_cfg.nc != '0)) begin
                    n_c     = '0;
                    n_j     = '0;
                    n_found = 1'b0;
                    n_state = S_JRD;
                end
            end
            S_JRD: begin
                if (r_j >= i_cfg.np) begin
                    n_state = S_OUT;
                end else begin
                    n_state = S_JCHK;
                end
            end
            S_JCHK: begin
                if (r_memb_q == w_tag) begin
                    n_k     = '0;
                    n_sum   = '0;
                    n_state = S_K;
                end else begin
                    n_j     = r_j + 1'b1;
                    n_state = S_JRD;
                end
            end
            S_K: begin
                if (r_k < i_cfg.np) begin
                    n_k       = r_k + 1'b1;
                    n_acc_vld = 1'b1;
                end else begin
                    n_state = S_KEND;
                end
            end
            S_KEND: begin
                if (!r_found || (r_sum < r_best_sum)) begin
                    n_found    = 1'b1;
                    n_best     = r_j[cmu_pkg::PT_W-1:0];
                    n_best_sum = r_sum;
                end
                n_j     = r_j + 1'b1;
                n_state = S_JRD;
            end
            S_OUT: begin
                if (!r_o_valid || m_axis_tready) begin
                    n_o_valid = 1'b1;
                    n_o_idx   = r_c[cmu_pkg::CID_W-1:0];
                    n_o_med   = r_found ? cmu_pkg::MEDIAN_W'(r_best) : '0;
                    n_o_empty = !r_found;
                    n_o_cost  = r_found ? cmu_pkg::sat_cost(r_best_sum) : '0;
                    n_o_last  = w_is_last;
                    if (w_is_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_c     = r_c + 1'b1;
                        n_j     = '0;
                        n_found = 1'b0;
                        n_state = S_JRD;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_c       <= '0;
            r_j       <= '0;
            r_k       <= '0;
            r_acc_vld <= 1'b0;
            r_found   <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_c       <= n_c;
            r_j       <= n_j;
            r_k       <= n_k;
            r_acc_vld <= n_acc_vld;
            r_found   <= n_found;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sum      <= n_sum;
        r_best_sum <= n_best_sum;
        r_best     <= n_best;
        r_o_idx    <= n_o_idx;
        r_o_med    <= n_o_med;
        r_o_empty  <= n_o_empty;
        r_o_cost   <= n_o_cost;
        r_o_last   <= n_o_last;
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = {3'b000, r_o_cost, r_o_med, r_o_idx};
    assign m_axis_tuser  = r_o_empty;
    assign m_axis_tlast  = r_o_last;
endmodule

>>> rtl/core/cluster_medoid_update.sv
// Top level of the cluster medoid update block: configuration registers and the two halves.
// Load transactions (membership or distance entry) are taken one per cycle while no run
// is in progress. A run transaction walks the clusters in order and emits one result per
// cluster; the search for each cluster is paced by the single read port of the distance
// memory, which delivers one entry per cycle to the cost accumulator. Stores are not
// cleared at reset; entries must be loaded before a run reads them. Input transactions
// keep queuing (two deep) while a run is in progress, and the result register lets the
// search go on while a result waits.
`timescale 1ns / 1ps
module cluster_medoid_update (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // row_point[7:0], col_point[15:8], cluster_id[20:16], is_assigned[21],
    // distance[53:22], zero pad[55:54]
    input  logic [cmu_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // cmd[1:0]
    input  logic [cmu_pkg::IN_USER_W-1:0]  s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // cluster_index[4:0], new_median[12:5], best_cost[52:13], zero pad[55:53]
    output logic [cmu_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // cluster_empty[0]
    output logic [cmu_pkg::OUT_USER_W-1:0] m_axis_tuser,
    output logic                           m_axis_tlast,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [cmu_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [cmu_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    logic [cmu_pkg::PCFG_W-1:0] r_point_count;
    logic [cmu_pkg::CCNT_W-1:0] r_median_count;
    cmu_pkg::t_run_cfg          w_cfg;
    cmu_pkg::t_item             w_item;
    logic                       w_item_valid;
    logic                       w_item_pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_point_count  <= cmu_pkg::PCFG_W'(256);
            r_median_count <= cmu_pkg::CCNT_W'(2);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                cmu_pkg::REG_POINT_COUNT:  r_point_count  <= i_cfg_data;
                cmu_pkg::REG_MEDIAN_COUNT: r_median_count <= i_cfg_data[cmu_pkg::CCNT_W-1:0];
                default: ;
            endcase
        end
    end

    assign w_cfg.np = (32'(r_point_count) > cmu_pkg::MAX_POINTS) ?
                      cmu_pkg::PCNT_W'(cmu_pkg::MAX_POINTS) :
                      cmu_pkg::PCNT_W'(r_point_count);
    assign w_cfg.nc = (32'(r_median_count) > cmu_pkg::CL_LIMIT) ?
                      cmu_pkg::CCNT_W'(cmu_pkg::CL_LIMIT) : r_median_count;

    cmu_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .o_item        (w_item),
        .o_item_valid  (w_item_valid),
        .i_item_pop    (w_item_pop)
    );

    cmu_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_item        (w_item),
        .i_item_valid  (w_item_valid),
        .o_item_pop    (w_item_pop),
        .i_cfg         (w_cfg),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );
endmodule

>>> rtl/core/cmu_check.sv
// Port-level checker for the cluster medoid update block, bound to the top level.
`timescale 1ns / 1ps
`include "cluster_medoid_update_defines.svh"
module cmu_check (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           s_axis_tvalid,
    input logic                           s_axis_tready,
    input logic [cmu_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    input logic [cmu_pkg::IN_USER_W-1:0]  s_axis_tuser,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [cmu_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input logic [cmu_pkg::OUT_USER_W-1:0] m_axis_tuser,
    input logic                           m_axis_tlast,
    input logic                           i_cfg_valid,
    input logic                           o_cfg_ready,
    input logic [cmu_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input logic [cmu_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    logic [cmu_pkg::CID_W-1:0] r_exp_idx;
    logic                      w_out_xfer;

    assign w_out_xfer = m_axis_tvalid && m_axis_tready;

    // next expected cluster index: restarts after the final result of a run
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_idx <= '0;
        end else if (w_out_xfer) begin
            r_exp_idx <= m_axis_tlast ? '0 : r_exp_idx + 1'b1;
        end
    end

    `CMU_ASSERT_RST(a_reset_no_result, !i_rst_n |=> !m_axis_tvalid, "result valid after reset")
    `CMU_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")
    `CMU_ASSERT(a_empty_zero, m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[52:5] == 48'd0, "empty cluster with median or cost")
    `CMU_ASSERT(a_idx_order, m_axis_tvalid |-> m_axis_tdata[4:0] == r_exp_idx, "cluster index out of order")
endmodule

bind cluster_medoid_update cmu_check u_cmu_check (.*);
